>>> src/fabd_pkg.sv
// Shared types and constants of the face anchor box decoder.
`default_nettype none

package fabd_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SCORE_THRESHOLD = 2'd0,
		REG_INVERSE_SCALE   = 2'd1,
		REG_IMAGE_WIDTH     = 2'd2,
		REG_IMAGE_HEIGHT    = 2'd3
	} reg_index_t;

	localparam int unsigned CFG_DATA_W = 24;

	// ln(2) in Q.28 and 2^22 / (ln(2) * 4096), the reciprocal for the range estimate.
	localparam logic [27:0] LN2_Q28     = 28'd186065279;
	localparam logic [11:0] INV_LN2_EST = 12'd1477;

	// Floor division of a value below 2^29 by n as (t * RECIP[n]) >> 34.
	localparam int unsigned TAYLOR_TERMS = 12;
	localparam logic [33:0] TAYLOR_RECIP [2:12] = '{
		34'd8589934592, 34'd5726623062, 34'd4294967296, 34'd3435973837,
		34'd2863311531, 34'd2454267027, 34'd2147483648, 34'd1908874354,
		34'd1717986919, 34'd1561806290, 34'd1431655766
	};

	// Pipeline depths of the arithmetic units.
	localparam int unsigned EXP_LAT  = 27;
	localparam int unsigned SQRT_LAT = 18;
	localparam int unsigned BOX_LAT  = 4;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic [14:0] DIM_MAX = 15'd16384;

	typedef struct packed {
		logic signed [15:0] class_prob;
		logic signed [15:0] object_prob;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic signed [15:0] log_width;
		logic signed [15:0] log_height;
		logic [7:0]         cell_row;
		logic [7:0]         cell_col;
		logic [1:0]         level;
	} grid_t;

	typedef struct packed {
		logic        kept;
		logic [15:0] score;
		logic [17:0] box_left;
		logic [17:0] box_top;
		logic [18:0] box_width;
		logic [18:0] box_height;
	} det_t;

	// A classified cell as it waits in the queue.
	typedef struct packed {
		logic [12:0]        class_p;
		logic [12:0]        object_p;
		logic signed [15:0] log_width;
		logic signed [15:0] log_height;
		logic [31:0]        ctr2_x;
		logic [31:0]        ctr2_y;
		logic [2:0]         shift;
		logic               in_grid;
	} cls_t;

	// Configuration as the back end sees it, image limits already in Q.4.
	typedef struct packed {
		logic [15:0] score_threshold;
		logic [23:0] inverse_scale;
		logic [17:0] left_max;
		logic [17:0] top_max;
		logic [18:0] right_max;
		logic [18:0] bottom_max;
	} cfg_t;

endpackage

`default_nettype wire

>>> src/fabd_chan_if.sv
// Valid/ready channel carrying one payload beat.
`default_nettype none

interface fabd_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/fabd_front.sv
// Front end: takes grid cells and classifies them for the queue.
`default_nettype none

module fabd_front #(
	parameter int unsigned INPUT_SIZE = 640
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	fabd_chan_if.sink     grid,
	output fabd_pkg::cls_t cls,
	output logic          cls_valid,
	input  wire logic     cls_ready
);

	fabd_pkg::cls_t     cls_q;
	logic               valid_q;
	fabd_pkg::cls_t     cls_next;
	logic [2:0]         shift;
	logic [8:0]         cells;
	logic signed [21:0] base_x;
	logic signed [21:0] base_y;

	function automatic logic [12:0] clamp_prob(input logic signed [15:0] v);
		logic [12:0] r;
		if (v[15]) begin
			r = 13'd0;
		end else if (v > 16'sd4096) begin
			r = 13'd4096;
		end else begin
			r = v[12:0];
		end
		return r;
	endfunction

	always_comb begin
		case (grid.data.level)
			2'd0: begin
				shift = 3'd3;
				cells = 9'(INPUT_SIZE / 8);
			end
			2'd1: begin
				shift = 3'd4;
				cells = 9'(INPUT_SIZE / 16);
			end
			default: begin
				shift = 3'd5;
				cells = 9'(INPUT_SIZE / 32);
			end
		endcase
		base_x = $signed({2'b00, grid.data.cell_col, 12'h000})
			+ $signed({{6{grid.data.offset_x[15]}}, grid.data.offset_x});
		base_y = $signed({2'b00, grid.data.cell_row, 12'h000})
			+ $signed({{6{grid.data.offset_y[15]}}, grid.data.offset_y});
		cls_next.class_p    = clamp_prob(grid.data.class_prob);
		cls_next.object_p   = clamp_prob(grid.data.object_prob);
		cls_next.log_width  = grid.data.log_width;
		cls_next.log_height = grid.data.log_height;
		// Twice the centre in Q.16: (cell + offset) * stride * 32.
		cls_next.ctr2_x = {{10{base_x[21]}}, base_x} << (4'(shift) + 4'd5);
		cls_next.ctr2_y = {{10{base_y[21]}}, base_y} << (4'(shift) + 4'd5);
		cls_next.shift  = shift;
		cls_next.in_grid = (grid.data.level != 2'd3)
			&& ({1'b0, grid.data.cell_row} < cells)
			&& ({1'b0, grid.data.cell_col} < cells);
	end

	assign grid.ready = !valid_q || cls_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (grid.ready) begin
			valid_q <= grid.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (grid.valid && grid.ready) begin
			cls_q <= cls_next;
		end
	end

	assign cls       = cls_q;
	assign cls_valid = valid_q;

endmodule

`default_nettype wire

>>> src/fabd_queue.sv
// Small register queue between the front and back ends.
`default_nettype none

module fabd_queue #(
	parameter type         T     = logic,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire T     push_data,
	input  wire logic push_valid,
	output logic      push_ready,
	output T          pop_data,
	output logic      pop_valid,
	input  wire logic pop_ready
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> src/fabd_sqrt.sv
// Pipelined integer square root of the clamped probability product.
`default_nettype none

module fabd_sqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [12:0] class_p,
	input  wire logic [12:0] object_p,
	output logic [15:0]      score
);

	localparam int unsigned STEPS = 17;

	logic [25:0] prod;
	logic [32:0] x_s [0:STEPS];
	logic [32:0] res_s [1:STEPS];
	logic [32:0] x_next [1:STEPS];
	logic [32:0] res_next [1:STEPS];

	assign prod = class_p * object_p;

	// One result bit per stage, from 4^16 down to 4^0.
	always_comb begin
		logic [32:0] res_in;
		logic [33:0] trial;
		logic [32:0] bit_v;
		for (int i = 1; i <= STEPS; i++) begin
			res_in = (i == 1) ? 33'd0 : res_s[(i == 1) ? 1 : i - 1];
			bit_v  = 33'd1 << (2 * (STEPS - i));
			trial  = {1'b0, res_in} + {1'b0, bit_v};
			if ({1'b0, x_s[i-1]} >= trial) begin
				x_next[i]   = 33'({1'b0, x_s[i-1]} - trial);
				res_next[i] = (res_in >> 1) + bit_v;
			end else begin
				x_next[i]   = x_s[i-1];
				res_next[i] = res_in >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= {prod[24:0], 8'h00};
			for (int i = 1; i <= STEPS; i++) begin
				x_s[i]   <= x_next[i];
				res_s[i] <= res_next[i];
			end
		end
	end

	assign score = (|res_s[STEPS][32:16]) ? 16'hFFFF : res_s[STEPS][15:0];

endmodule

`default_nettype wire

>>> src/fabd_exp.sv
// Pipelined e^v for signed Q4.12 input, unsigned Q13.16 result.
`default_nettype none

module fabd_exp (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [15:0] v,
	output logic [28:0]             result
);

	localparam int unsigned N = fabd_pkg::TAYLOR_TERMS;

	logic signed [15:0] v_s1;
	logic signed [6:0]  kest_s1;
	logic signed [35:0] r0_s2;
	logic signed [6:0]  k_s2;
	logic [27:0]        r_s3;
	logic signed [6:0]  k_s3;

	// Taylor stages: "a" holds the quotient product, "b" the new term folded in.
	logic [62:0]        q_sa   [2:N];
	logic [29:0]        sum_sa [2:N];
	logic [27:0]        r_sa   [2:N];
	logic signed [6:0]  k_sa   [2:N];
	logic [56:0]        prod_sb [1:N];
	logic [29:0]        sum_sb  [1:N];
	logic [27:0]        r_sb    [1:N];
	logic signed [6:0]  k_sb    [1:N];
	logic [28:0]        result_q;

	logic signed [28:0] kprod;
	logic signed [35:0] r0;
	logic [4:0]         sh;
	logic signed [6:0]  sh_full;
	logic [30:0]        rnd;

	assign kprod = v * $signed({1'b0, fabd_pkg::INV_LN2_EST});
	assign r0 = $signed({{4{v_s1[15]}}, v_s1, 16'h0000})
		- kest_s1 * $signed({1'b0, fabd_pkg::LN2_Q28});

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1    <= v;
			kest_s1 <= kprod[28:22];
			r0_s2   <= r0;
			k_s2    <= kest_s1;
			// The estimate is off by at most one step of ln 2.
			if (r0_s2[35]) begin
				r_s3 <= 28'(r0_s2 + $signed({8'h00, fabd_pkg::LN2_Q28}));
				k_s3 <= k_s2 - 7'sd1;
			end else if (r0_s2 >= $signed({8'h00, fabd_pkg::LN2_Q28})) begin
				r_s3 <= 28'(r0_s2 - $signed({8'h00, fabd_pkg::LN2_Q28}));
				k_s3 <= k_s2 + 7'sd1;
			end else begin
				r_s3 <= r0_s2[27:0];
				k_s3 <= k_s2;
			end
			// First term of the series is r itself.
			sum_sb[1]  <= 30'h1000_0000 + 30'(r_s3);
			prod_sb[1] <= 57'(r_s3 * r_s3);
			r_sb[1]    <= r_s3;
			k_sb[1]    <= k_s3;
			for (int n = 2; n <= N; n++) begin
				q_sa[n]   <= prod_sb[n-1][56:28] * fabd_pkg::TAYLOR_RECIP[n];
				sum_sa[n] <= sum_sb[n-1];
				r_sa[n]   <= r_sb[n-1];
				k_sa[n]   <= k_sb[n-1];
				sum_sb[n]  <= sum_sa[n] + 30'(q_sa[n][62:34]);
				prod_sb[n] <= q_sa[n][62:34] * r_sa[n];
				r_sb[n]    <= r_sa[n];
				k_sb[n]    <= k_sa[n];
			end
			result_q <= rnd[29:1] >> (sh - 5'd1);
		end
	end

	// Scale by 2^(k-12) with round half up; k stays below 12 for any input.
	always_comb begin
		sh_full = 7'sd12 - k_sb[N];
		sh      = sh_full[4:0];
		rnd     = ({1'b0, sum_sb[N]} + (31'd1 << (sh - 5'd1))) >> 1;
		rnd     = rnd << 1;
	end

	assign result = result_q;

endmodule

`default_nettype wire

>>> src/fabd_back.sv
// Back end: score, exp and box arithmetic pipeline with the output register.
`default_nettype none

module fabd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire fabd_pkg::cls_t head,
	input  wire logic           head_valid,
	output logic                head_ready,
	input  wire fabd_pkg::cfg_t cfg,
	fabd_chan_if.source         det
);

	localparam int unsigned ELAT      = fabd_pkg::EXP_LAT;
	localparam int unsigned SCORE_DLY = fabd_pkg::EXP_LAT - fabd_pkg::SQRT_LAT;
	localparam int unsigned LAT       = fabd_pkg::EXP_LAT + fabd_pkg::BOX_LAT;

	typedef struct packed {
		logic [31:0] ctr2_x;
		logic [31:0] ctr2_y;
		logic [2:0]  shift;
		logic        in_grid;
	} side_t;

	logic             en;
	logic [LAT-1:0]   vld_q;
	side_t            side_s  [0:ELAT-1];
	logic [15:0]      score_s [0:SCORE_DLY-1];
	logic [28:0]      ew;
	logic [28:0]      eh;
	logic [15:0]      score_raw;
	side_t            sd;

	logic [33:0]        bw_s1, bh_s1;
	logic signed [35:0] edge_x_s1, edge_y_s1;
	logic               kept_s1, kept_s2, kept_s3;
	logic [15:0]        score_s1, score_s2, score_s3;
	logic signed [60:0] px_s2, py_s2;
	logic [57:0]        sw_s2, sh_s2;
	logic [17:0]        left_s3, top_s3;
	logic [30:0]        szw_s3, szh_s3;
	fabd_pkg::det_t     out_s4;

	logic [33:0]    bw, bh;
	logic [58:0]    sw_rnd, sh_rnd;
	logic [17:0]    left, top;

	function automatic logic [18:0] far_extent(input logic [17:0] start,
			input logic [30:0] sz, input logic [18:0] lim);
		logic [31:0] e;
		e = 32'(start) + 32'(sz);
		if (e < 32'(start) + 32'd16) begin
			e = 32'(start) + 32'd16;
		end
		if (e > 32'(lim)) begin
			e = 32'(lim);
		end
		return 19'(e - 32'(start));
	endfunction

	function automatic logic [17:0] near_edge(input logic signed [60:0] p,
			input logic [17:0] lim);
		logic [59:0] r;
		logic [17:0] e;
		r = p[59:0] + (60'd1 << 28);
		if (p[60]) begin
			e = 18'd0;
		end else if (r[59:29] > 31'(lim)) begin
			e = lim;
		end else begin
			e = r[46:29];
		end
		return e;
	endfunction

	assign en         = !vld_q[LAT-1] || det.ready;
	assign head_ready = en;

	fabd_exp u_exp_w (.clk(clk), .en(en), .v(head.log_width), .result(ew));
	fabd_exp u_exp_h (.clk(clk), .en(en), .v(head.log_height), .result(eh));
	fabd_sqrt u_sqrt (
		.clk(clk), .en(en), .class_p(head.class_p), .object_p(head.object_p),
		.score(score_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], head_valid};
		end
	end

	assign sd = side_s[ELAT-1];

	always_comb begin
		bw = {5'b0, ew} << sd.shift;
		bh = {5'b0, eh} << sd.shift;
		sw_rnd = 59'(sw_s2) + (59'd1 << 27);
		sh_rnd = 59'(sh_s2) + (59'd1 << 27);
		left   = near_edge(px_s2, cfg.left_max);
		top    = near_edge(py_s2, cfg.top_max);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= '{ctr2_x: head.ctr2_x, ctr2_y: head.ctr2_y,
				shift: head.shift, in_grid: head.in_grid};
			for (int i = 1; i < ELAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
			score_s[0] <= score_raw;
			for (int i = 1; i < SCORE_DLY; i++) begin
				score_s[i] <= score_s[i-1];
			end

			bw_s1     <= bw;
			bh_s1     <= bh;
			edge_x_s1 <= $signed({{4{sd.ctr2_x[31]}}, sd.ctr2_x}) - $signed({2'b00, bw});
			edge_y_s1 <= $signed({{4{sd.ctr2_y[31]}}, sd.ctr2_y}) - $signed({2'b00, bh});
			kept_s1   <= sd.in_grid && (score_s[SCORE_DLY-1] >= cfg.score_threshold);
			score_s1  <= score_s[SCORE_DLY-1];

			px_s2    <= edge_x_s1 * $signed({1'b0, cfg.inverse_scale});
			py_s2    <= edge_y_s1 * $signed({1'b0, cfg.inverse_scale});
			sw_s2    <= bw_s1 * cfg.inverse_scale;
			sh_s2    <= bh_s1 * cfg.inverse_scale;
			kept_s2  <= kept_s1;
			score_s2 <= score_s1;

			left_s3  <= left;
			top_s3   <= top;
			szw_s3   <= sw_rnd[58:28];
			szh_s3   <= sh_rnd[58:28];
			kept_s3  <= kept_s2;
			score_s3 <= score_s2;

			out_s4.kept       <= kept_s3;
			out_s4.score      <= score_s3;
			out_s4.box_left   <= kept_s3 ? left_s3 : 18'd0;
			out_s4.box_top    <= kept_s3 ? top_s3 : 18'd0;
			out_s4.box_width  <= kept_s3 ? far_extent(left_s3, szw_s3, cfg.right_max) : 19'd0;
			out_s4.box_height <= kept_s3 ? far_extent(top_s3, szh_s3, cfg.bottom_max) : 19'd0;
		end
	end

	assign det.valid = vld_q[LAT-1];
	assign det.data  = out_s4;

endmodule

`default_nettype wire

>>> src/face_anchor_box_decoder_unit.sv
// Top level of the face anchor box decoder: config registers, front end, queue, back end.
`default_nettype none

// Channel  Dir  Beat                      Handshake
// grid     in   fabd_pkg::grid_t (cell)   valid/ready, beat on valid & ready
// det      out  fabd_pkg::det_t (result)  valid/ready, beat on valid & ready
// cfg      in   cfg_index, cfg_data       write on cfg_we, no back-pressure
//
// A cell beat is taken each cycle that grid is ready and yields exactly one result beat.
// From a grid beat to its det beat the data passes one front register, the queue and
// 31 back-end stages, set by the 27-stage exp pipeline (range reduction, the first
// Taylor term, two stages per later term and the output scaling) and 4 box stages.
// A stall on det freezes the back end; the queue and front register keep taking
// cells until full, so grid stalls only after five cells pile up.
// Reset clears the valid bits and loads the config reset values; no clearing pass.

module face_anchor_box_decoder_unit #(
	parameter int unsigned INPUT_SIZE = 640
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	fabd_chan_if.sink                              grid,
	fabd_chan_if.source                            det,
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [fabd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [15:0] score_threshold_q;
	logic [23:0] inverse_scale_q;
	logic [14:0] image_width_q;
	logic [14:0] image_height_q;

	logic [14:0]    w_sat;
	logic [14:0]    h_sat;
	fabd_pkg::cfg_t cfg;

	fabd_pkg::cls_t front_cls;
	logic           front_valid;
	logic           front_ready;
	fabd_pkg::cls_t head;
	logic           head_valid;
	logic           head_ready;

	// Register writes; software must only write while the decoder is drained, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_threshold_q <= 16'd58982;
			inverse_scale_q   <= 24'd65536;
			image_width_q     <= 15'd640;
			image_height_q    <= 15'd640;
		end else if (cfg_we) begin
			case (cfg_index)
				fabd_pkg::REG_SCORE_THRESHOLD: score_threshold_q <= cfg_data[15:0];
				fabd_pkg::REG_INVERSE_SCALE:   inverse_scale_q   <= cfg_data[23:0];
				fabd_pkg::REG_IMAGE_WIDTH:     image_width_q     <= cfg_data[14:0];
				fabd_pkg::REG_IMAGE_HEIGHT:    image_height_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Image size is saturated into 1..16384 and turned into Q.4 edge limits.
	always_comb begin
		w_sat = (image_width_q == '0) ? 15'd1
			: (image_width_q > fabd_pkg::DIM_MAX) ? fabd_pkg::DIM_MAX : image_width_q;
		h_sat = (image_height_q == '0) ? 15'd1
			: (image_height_q > fabd_pkg::DIM_MAX) ? fabd_pkg::DIM_MAX : image_height_q;
		cfg.score_threshold = score_threshold_q;
		cfg.inverse_scale   = inverse_scale_q;
		cfg.left_max        = 18'({w_sat - 15'd1, 4'h0});
		cfg.top_max         = 18'({h_sat - 15'd1, 4'h0});
		cfg.right_max       = {w_sat, 4'h0};
		cfg.bottom_max      = {h_sat, 4'h0};
	end

	fabd_front #(.INPUT_SIZE(INPUT_SIZE)) u_front (
		.clk(clk), .arst_n(arst_n), .grid(grid),
		.cls(front_cls), .cls_valid(front_valid), .cls_ready(front_ready)
	);

	fabd_queue #(.T(fabd_pkg::cls_t), .DEPTH(fabd_pkg::QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_data(front_cls), .push_valid(front_valid), .push_ready(front_ready),
		.pop_data(head), .pop_valid(head_valid), .pop_ready(head_ready)
	);

	fabd_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_valid(head_valid),
		.head_ready(head_ready), .cfg(cfg), .det(det)
	);

`ifndef NO_ASSERTIONS
	// A kept box is at least one pixel in each direction.
	a_kept_min_size: assert property (@(posedge clk) disable iff (!arst_n)
		det.valid && det.data.kept |-> det.data.box_width >= 19'd16
			&& det.data.box_height >= 19'd16)
		else $error("kept box smaller than one pixel");

	// A dropped cell carries an empty box.
	a_drop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		det.valid && !det.data.kept |-> det.data.box_left == 18'd0
			&& det.data.box_top == 18'd0 && det.data.box_width == 19'd0
			&& det.data.box_height == 19'd0)
		else $error("dropped cell has a nonzero box");

	// Kept cells always reach the threshold.
	a_kept_score: assert property (@(posedge clk) disable iff (!arst_n)
		det.valid && det.data.kept |-> det.data.score >= score_threshold_q)
		else $error("kept cell below score threshold");
`endif

endmodule

`default_nettype wire
